// ===== rtl/core/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: command codes,
// control characters, configuration register indexes and the geometry and
// colour settings that travel from the top level to the sequencer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Command codes carried in the input beat's tuser.
    localparam logic [2:0] CMD_PRINT  = 3'd0;
    localparam logic [2:0] CMD_RAW    = 3'd1;
    localparam logic [2:0] CMD_SHADOW = 3'd2;
    localparam logic [2:0] CMD_SETPOS = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;
    localparam logic [2:0] CMD_READ   = 3'd5;

    // Control characters recognized by the print command, and the blank used to clear cells.
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_BLANK = 8'h20;

    // Cursor coordinates saturate here.
    localparam logic [9:0] CUR_MAX = 10'd1023;

    // Configuration register indexes.
    localparam logic [2:0] CFG_COLS       = 3'd0;
    localparam logic [2:0] CFG_ROWS       = 3'd1;
    localparam logic [2:0] CFG_MONO       = 3'd2;
    localparam logic [2:0] CFG_COLOUR     = 3'd3;
    localparam logic [2:0] CFG_SHD_LIGHT  = 3'd4;
    localparam logic [2:0] CFG_SHD_DARK   = 3'd5;

    // Configuration reset values.
    localparam logic [6:0] RST_COLS      = 7'd40;
    localparam logic [5:0] RST_ROWS      = 6'd30;
    localparam logic [7:0] RST_COLOUR    = 8'd15;
    localparam logic [7:0] RST_SHD_LIGHT = 8'd128;
    localparam logic [7:0] RST_SHD_DARK  = 8'd8;

    // Effective settings, with the geometry already limited to the store size.
    typedef struct packed {
        logic [6:0] vis_cols;
        logic [5:0] vis_rows;
        logic       mono;
        logic [7:0] colour;
        logic [7:0] shd_light;
        logic [7:0] shd_dark;
    } t_cfg;

endpackage

// ===== rtl/core/tcw_cell_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_cell_ram
// Screen cell store: a character array and an attribute array sharing one
// write address and one read address, with registered read data.
// ----------------------------------------------------------------------------
module tcw_cell_ram #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic          i_clk,
    input  logic          i_we_char,
    input  logic          i_we_attr,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wchar,
    input  logic [7:0]    i_wattr,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rchar,
    output logic [7:0]    o_rattr
);

    logic [7:0] r_char_mem [DEPTH];
    logic [7:0] r_attr_mem [DEPTH];
    logic [7:0] r_rchar;
    logic [7:0] r_rattr;

    always_ff @(posedge i_clk) begin
        if (i_we_char) begin
            r_char_mem[i_waddr] <= i_wchar;
        end
        if (i_we_attr) begin
            r_attr_mem[i_waddr] <= i_wattr;
        end
        r_rchar <= r_char_mem[i_raddr];
        r_rattr <= r_attr_mem[i_raddr];
    end

    assign o_rchar = r_rchar;
    assign o_rattr = r_rattr;

endmodule

// ===== rtl/core/tcw_seq.sv =====
// ----------------------------------------------------------------------------
// tcw_seq
// Command sequencer: cursor, single-cell read-modify-write, the scroll and
// clear sweeps over the cell store, and the result register.
// ----------------------------------------------------------------------------
module tcw_seq
    import tcw_pkg::*;
#(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 32,
    parameter int AW       = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    // command beats
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [2:0]    i_cmd,
    input  logic [7:0]    i_char,
    input  logic [9:0]    i_px,
    input  logic [9:0]    i_py,
    // result beats
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [9:0]    o_col,
    output logic [9:0]    o_row,
    output logic [7:0]    o_cchar,
    output logic [7:0]    o_cattr,
    // cell store
    output logic          o_we_char,
    output logic          o_we_attr,
    output logic [AW-1:0] o_waddr,
    output logic [7:0]    o_wchar,
    output logic [7:0]    o_wattr,
    output logic [AW-1:0] o_raddr,
    input  logic [7:0]    i_rchar,
    input  logic [7:0]    i_rattr
);

    localparam int CWI = $clog2(MAX_COLS);
    localparam int RWI = $clog2(MAX_ROWS);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_COPY  = 5'b00100,
        S_BLANK = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    function automatic logic [AW-1:0] f_cell(input logic [RWI-1:0] a_row,
                                             input logic [CWI-1:0] a_col);
        f_cell = AW'(int'(a_row) * MAX_COLS + int'(a_col));
    endfunction

    t_state          r_state, n_state;
    logic [9:0]      r_x, n_x;
    logic [9:0]      r_y, n_y;
    logic [RWI-1:0]  r_srow, n_srow;
    logic [CWI-1:0]  r_scol, n_scol;
    logic            r_wq_valid, n_wq_valid;
    logic [AW-1:0]   r_wq_addr, n_wq_addr;
    logic            r_wq_copy, n_wq_copy;
    logic            r_out_valid, n_out_valid;
    logic [9:0]      r_oc, n_oc;
    logic [9:0]      r_or, n_or;
    logic [7:0]      r_ochar, n_ochar;
    logic [7:0]      r_oattr, n_oattr;
    logic [7:0]      r_res_c, n_res_c;
    logic [7:0]      r_res_a, n_res_a;
    logic [2:0]      r_cmd, n_cmd;
    logic [7:0]      r_ch, n_ch;
    logic [9:0]      r_px, n_px;
    logic [9:0]      r_py, n_py;
    logic            r_hit, n_hit;
    logic [AW-1:0]   r_addr, n_addr;

    logic            out_free;
    logic            cur_hit;
    logic            pos_hit;
    logic            geo_empty;
    logic            col_last;
    logic            row_last;
    logic            copy_row_last;
    logic [RWI-1:0]  bottom_row;
    logic [RWI-1:0]  src_row;
    logic [9:0]      adv_x;
    logic [10:0]     tab_sum;
    logic [9:0]      tab_x;
    logic            lf_scroll;
    logic [7:0]      shd_attr;
    logic            finish;
    logic            ex_we_char;
    logic            ex_we_attr;
    logic [7:0]      ex_wattr;
    logic [7:0]      rc;
    logic [7:0]      ra;

    assign out_free      = !r_out_valid || i_out_ready;
    assign cur_hit       = (r_x < 10'(i_cfg.vis_cols)) && (r_y < 10'(i_cfg.vis_rows));
    assign pos_hit       = (i_px < 10'(i_cfg.vis_cols)) && (i_py < 10'(i_cfg.vis_rows));
    assign geo_empty     = (i_cfg.vis_cols == '0) || (i_cfg.vis_rows == '0);
    assign col_last      = (9'(r_scol) + 9'd1) == 9'(i_cfg.vis_cols);
    assign row_last      = (8'(r_srow) + 8'd1) == 8'(i_cfg.vis_rows);
    assign copy_row_last = (8'(r_srow) + 8'd2) == 8'(i_cfg.vis_rows);
    assign bottom_row    = RWI'(8'(i_cfg.vis_rows) - 8'd1);
    assign src_row       = RWI'(r_srow + 1'b1);
    assign adv_x         = (r_x < CUR_MAX) ? r_x + 10'd1 : r_x;
    assign tab_sum       = 11'(r_x) + 11'd7;
    assign tab_x         = tab_sum[10] ? CUR_MAX : {tab_sum[9:3], 3'b000};
    assign lf_scroll     = (11'(r_y) + 11'd1) >= 11'(i_cfg.vis_rows);
    // A foreground darker than its background gets the light shadow.
    assign shd_attr      = (i_rattr[3:0] < i_rattr[7:4]) ? i_cfg.shd_light : i_cfg.shd_dark;

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_y         = r_y;
        n_srow      = r_srow;
        n_scol      = r_scol;
        n_wq_valid  = 1'b0;
        n_wq_addr   = r_wq_addr;
        n_wq_copy   = r_wq_copy;
        n_out_valid = r_out_valid && !i_out_ready;
        n_oc        = r_oc;
        n_or        = r_or;
        n_ochar     = r_ochar;
        n_oattr     = r_oattr;
        n_res_c     = r_res_c;
        n_res_a     = r_res_a;
        n_cmd       = r_cmd;
        n_ch        = r_ch;
        n_px        = r_px;
        n_py        = r_py;
        n_hit       = r_hit;
        n_addr      = r_addr;
        o_raddr     = r_addr;
        finish      = 1'b0;
        ex_we_char  = 1'b0;
        ex_we_attr  = 1'b0;
        ex_wattr    = i_cfg.colour;
        rc          = 8'd0;
        ra          = 8'd0;

        case (r_state)
            S_IDLE: begin
                // The read of the addressed cell starts with the accept, so its
                // data is ready in the execute cycle.
                if (i_cmd == CMD_READ) begin
                    n_hit  = pos_hit;
                    n_addr = f_cell(i_py[RWI-1:0], i_px[CWI-1:0]);
                end else begin
                    n_hit  = cur_hit;
                    n_addr = f_cell(r_y[RWI-1:0], r_x[CWI-1:0]);
                end
                o_raddr = n_addr;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                    n_cmd   = i_cmd;
                    n_ch    = i_char;
                    n_px    = i_px;
                    n_py    = i_py;
                end
            end
            S_EXEC: begin
                case (r_cmd)
                    CMD_PRINT, CMD_RAW: begin
                        if (r_cmd == CMD_PRINT && r_ch == CH_CR) begin
                            n_x    = '0;
                            finish = 1'b1;
                        end else if (r_cmd == CMD_PRINT && r_ch == CH_LF) begin
                            n_x = '0;
                            if (!lf_scroll) begin
                                n_y    = r_y + 10'd1;
                                finish = 1'b1;
                            end else if (geo_empty) begin
                                finish = 1'b1;
                            end else if (i_cfg.vis_rows == 6'd1) begin
                                n_state = S_BLANK;
                                n_srow  = bottom_row;
                                n_scol  = '0;
                            end else begin
                                n_state = S_COPY;
                                n_srow  = '0;
                                n_scol  = '0;
                            end
                        end else if (r_cmd == CMD_PRINT && r_ch == CH_TAB) begin
                            n_x    = tab_x;
                            finish = 1'b1;
                        end else begin
                            ex_we_char = r_hit;
                            ex_we_attr = r_hit && !i_cfg.mono;
                            n_x        = adv_x;
                            finish     = 1'b1;
                        end
                    end
                    CMD_SHADOW: begin
                        ex_we_attr = r_hit && !i_cfg.mono;
                        ex_wattr   = shd_attr;
                        n_x        = adv_x;
                        finish     = 1'b1;
                    end
                    CMD_SETPOS: begin
                        n_x    = r_px;
                        n_y    = r_py;
                        finish = 1'b1;
                    end
                    CMD_CLEAR: begin
                        n_x = '0;
                        n_y = '0;
                        if (geo_empty) begin
                            finish = 1'b1;
                        end else begin
                            n_state = S_BLANK;
                            n_srow  = '0;
                            n_scol  = '0;
                        end
                    end
                    CMD_READ: begin
                        if (r_hit) begin
                            rc = i_rchar;
                            ra = i_rattr;
                        end
                        finish = 1'b1;
                    end
                    default: begin
                        finish = 1'b1;
                    end
                endcase
                n_res_c = rc;
                n_res_a = ra;
                if (finish) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_oc        = n_x;
                        n_or        = n_y;
                        n_ochar     = rc;
                        n_oattr     = ra;
                        n_state     = S_IDLE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_COPY: begin
                // Read the cell one row down; it is written one row up in
                // the next cycle through the write stage.
                o_raddr    = f_cell(src_row, r_scol);
                n_wq_valid = 1'b1;
                n_wq_addr  = f_cell(r_srow, r_scol);
                n_wq_copy  = 1'b1;
                if (col_last) begin
                    n_scol = '0;
                    if (copy_row_last) begin
                        n_state = S_BLANK;
                        n_srow  = bottom_row;
                    end else begin
                        n_srow = src_row;
                    end
                end else begin
                    n_scol = CWI'(r_scol + 1'b1);
                end
            end
            S_BLANK: begin
                n_wq_valid = 1'b1;
                n_wq_addr  = f_cell(r_srow, r_scol);
                n_wq_copy  = 1'b0;
                if (col_last) begin
                    n_scol = '0;
                    if (row_last) begin
                        n_state = S_DONE;
                    end else begin
                        n_srow = RWI'(r_srow + 1'b1);
                    end
                end else begin
                    n_scol = CWI'(r_scol + 1'b1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_oc        = r_x;
                    n_or        = r_y;
                    n_ochar     = r_res_c;
                    n_oattr     = r_res_a;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // One write port: the sweep's write stage, otherwise a single-cell write.
    always_comb begin
        if (r_wq_valid) begin
            o_we_char = 1'b1;
            o_we_attr = !i_cfg.mono;
            o_waddr   = r_wq_addr;
            o_wchar   = r_wq_copy ? i_rchar : CH_BLANK;
            o_wattr   = r_wq_copy ? i_rattr : i_cfg.colour;
        end else begin
            o_we_char = ex_we_char;
            o_we_attr = ex_we_attr;
            o_waddr   = r_addr;
            o_wchar   = r_ch;
            o_wattr   = ex_wattr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_x         <= '0;
            r_y         <= '0;
            r_wq_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_x         <= n_x;
            r_y         <= n_y;
            r_wq_valid  <= n_wq_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_srow    <= n_srow;
        r_scol    <= n_scol;
        r_wq_addr <= n_wq_addr;
        r_wq_copy <= n_wq_copy;
        r_oc      <= n_oc;
        r_or      <= n_or;
        r_ochar   <= n_ochar;
        r_oattr   <= n_oattr;
        r_res_c   <= n_res_c;
        r_res_a   <= n_res_a;
        r_cmd     <= n_cmd;
        r_ch      <= n_ch;
        r_px      <= n_px;
        r_py      <= n_py;
        r_hit     <= n_hit;
        r_addr    <= n_addr;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_col       = r_oc;
    assign o_row       = r_or;
    assign o_cchar     = r_ochar;
    assign o_cattr     = r_oattr;

endmodule

// ===== rtl/core/text_console_writer_unit.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Character-cell text screen with cursor: print, raw print, shadow, set
// position, clear and read-cell commands over a character and attribute store.
// ----------------------------------------------------------------------------
// Usage. Command beats enter on the s_axis channel (command code in tuser,
// character and coordinates in tdata); every command returns exactly one
// result beat on the m_axis channel with the cursor after the command and, for
// a read, the cell's character and attribute (zero otherwise).
// Settings are written through the plain write port while no command is in
// flight; the geometry is limited to MAX_COLS by MAX_ROWS.
// Timing. A command is taken while the sequencer is idle and executed in the
// next cycle, where its single read-modify-write of the cell store happens;
// its result is registered when the command completes, and no new command
// is taken until the sequencer is back in idle. A clear sweeps the visible
// cells one per cycle, and a line feed that scrolls copies each visible row
// below the top up one row, one cell per cycle, and blanks the bottom row;
// both sweeps go one cell at a time because the store has a single write port.
// Reset clears the cursor to the top-left corner and loads the settings'
// defaults; the cell store is not cleared and holds unknown data until it is
// written by a print, a clear or a scroll. If the receiver stalls, the result
// stays in the output register; one more command is accepted and finishes its
// work, then waits until the output register is free.
// ----------------------------------------------------------------------------
module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata,
    // command channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // char_code[7:0], pos_x[17:8], pos_y[27:18]
    input  logic [2:0]  s_axis_tuser,   // cmd[2:0]
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // cursor_col[9:0], cursor_row[19:10],
                                        // cell_char[27:20], cell_attr[35:28]
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);

    // Settings registers.
    logic [6:0] r_cols;
    logic [5:0] r_rows;
    logic       r_mono;
    logic [7:0] r_colour;
    logic [7:0] r_shd_light;
    logic [7:0] r_shd_dark;

    t_cfg       cfg;

    logic          we_char;
    logic          we_attr;
    logic [AW-1:0] waddr;
    logic [7:0]    wchar;
    logic [7:0]    wattr;
    logic [AW-1:0] raddr;
    logic [7:0]    rchar;
    logic [7:0]    rattr;

    logic [9:0]    out_col;
    logic [9:0]    out_row;
    logic [7:0]    out_char;
    logic [7:0]    out_attr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols      <= RST_COLS;
            r_rows      <= RST_ROWS;
            r_mono      <= 1'b0;
            r_colour    <= RST_COLOUR;
            r_shd_light <= RST_SHD_LIGHT;
            r_shd_dark  <= RST_SHD_DARK;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COLS:      r_cols      <= i_cfg_wdata[6:0];
                CFG_ROWS:      r_rows      <= i_cfg_wdata[5:0];
                CFG_MONO:      r_mono      <= i_cfg_wdata[0];
                CFG_COLOUR:    r_colour    <= i_cfg_wdata;
                CFG_SHD_LIGHT: r_shd_light <= i_cfg_wdata;
                CFG_SHD_DARK:  r_shd_dark  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Geometry larger than the store acts as the full store. The clamped value
    // always fits the register width, since it is only taken when the store
    // is smaller than the register's value.
    always_comb begin
        cfg.vis_cols  = (32'(r_cols) > MAX_COLS) ? 7'(MAX_COLS) : r_cols;
        cfg.vis_rows  = (32'(r_rows) > MAX_ROWS) ? 6'(MAX_ROWS) : r_rows;
        cfg.mono      = r_mono;
        cfg.colour    = r_colour;
        cfg.shd_light = r_shd_light;
        cfg.shd_dark  = r_shd_dark;
    end

    tcw_cell_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we_char (we_char),
        .i_we_attr (we_attr),
        .i_waddr   (waddr),
        .i_wchar   (wchar),
        .i_wattr   (wattr),
        .i_raddr   (raddr),
        .o_rchar   (rchar),
        .o_rattr   (rattr)
    );

    tcw_seq #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .AW       (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_cmd       (s_axis_tuser),
        .i_char      (s_axis_tdata[7:0]),
        .i_px        (s_axis_tdata[17:8]),
        .i_py        (s_axis_tdata[27:18]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_col       (out_col),
        .o_row       (out_row),
        .o_cchar     (out_char),
        .o_cattr     (out_attr),
        .o_we_char   (we_char),
        .o_we_attr   (we_attr),
        .o_waddr     (waddr),
        .o_wchar     (wchar),
        .o_wattr     (wattr),
        .o_raddr     (raddr),
        .i_rchar     (rchar),
        .i_rattr     (rattr)
    );

    assign m_axis_tdata = {4'b0000, out_attr, out_char, out_row, out_col};

endmodule
